// ----- hdl/iiel_pkg.sv -----
`timescale 1ns / 1ps

package iiel_pkg;

    // Storage geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = 5;
    localparam int POS_W      = 5;
    localparam int CMD_W      = 4;
    localparam int ST_W       = 2;

    // Command codes as they arrive on the input channel
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND      = 4'd0,
        CMD_REMOVE_LAST = 4'd1,
        CMD_INSERT      = 4'd2,
        CMD_ERASE       = 4'd3,
        CMD_READ        = 4'd4,
        CMD_WRITE       = 4'd5,
        CMD_FRONT       = 4'd6,
        CMD_BACK        = 4'd7,
        CMD_CLEAR       = 4'd8
    } cmd_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Operation the datapath carries out once checks have passed
    typedef enum logic [3:0] {
        OP_NONE,
        OP_APPEND,
        OP_POP,
        OP_INSERT,
        OP_ERASE,
        OP_READ,
        OP_WRITE,
        OP_FRONT,
        OP_BACK,
        OP_CLEAR
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    latch_in;
        logic    exec;
        dp_op_t  op;
        status_t status;
    } dp_ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             pos_gt_cnt;
        logic             pos_ge_cnt;
    } dp_stat_t;

endpackage

// ----- hdl/indexed_insert_erase_list.sv -----
`timescale 1ns / 1ps
// Channel | Direction | tdata (low bit up)                        | tuser
// s_      | in        | position[4:0], item_value[36:5]           | command[3:0]
// m_      | out       | read_value[31:0], status[33:32],          | -
//         |           | entry_count[38:34]                        |
//
// Each item is first captured, then run through the sixteen-cell shift row,
// whose cells all move in parallel.
// The result sits in an output register; the next item is taken while it waits.
// Execution holds while the output register is full and not being taken.
// Reset clears the entry count and the handshake state; entries need no clearing.

module indexed_insert_erase_list
    import iiel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position, item_value, zero fill
    input  logic [3:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_value, status, entry_count, zero fill
);

    dp_ctrl_t              ctrl;
    dp_stat_t              stat;
    logic [DATA_WIDTH-1:0] read_value;
    logic [ST_W-1:0]       status;
    logic [CNT_W-1:0]      entry_count;

    iiel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    iiel_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_cmd      (s_tuser),
        .in_pos      (s_tdata[4:0]),
        .in_value    (s_tdata[36:5]),
        .ctrl        (ctrl),
        .stat        (stat),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count)
    );

    // Pack the result item
    assign m_tdata = {1'b0, entry_count, status, read_value};

endmodule

// ----- hdl/iiel_ctrl.sv -----
`timescale 1ns / 1ps

module iiel_ctrl
    import iiel_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    logic    exec;
    dp_op_t  op;
    status_t st;

    // Fire the execute step once the output register is free
    assign exec      = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Check the latched command against the count and pick the operation
    always_comb
    begin
        op = OP_NONE;
        st = ST_OK;
        unique case (stat.cmd)
            CMD_APPEND:
            begin
                if (stat.full) st = ST_FULL;
                else           op = OP_APPEND;
            end
            CMD_REMOVE_LAST:
            begin
                if (!stat.empty) op = OP_POP;
            end
            CMD_INSERT:
            begin
                if (stat.pos_gt_cnt) st = ST_RANGE;
                else if (stat.full)  st = ST_FULL;
                else                 op = OP_INSERT;
            end
            CMD_ERASE:
            begin
                if (stat.pos_ge_cnt) st = ST_RANGE;
                else                 op = OP_ERASE;
            end
            CMD_READ:
            begin
                if (stat.pos_ge_cnt) st = ST_RANGE;
                else                 op = OP_READ;
            end
            CMD_WRITE:
            begin
                if (stat.pos_ge_cnt) st = ST_RANGE;
                else                 op = OP_WRITE;
            end
            CMD_FRONT:
            begin
                if (stat.empty) st = ST_EMPTY;
                else            op = OP_FRONT;
            end
            CMD_BACK:
            begin
                if (stat.empty) st = ST_EMPTY;
                else            op = OP_BACK;
            end
            CMD_CLEAR:
            begin
                op = OP_CLEAR;
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    // Next state and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign ctrl.latch_in = in_valid && in_ready;
    assign ctrl.exec     = exec;
    assign ctrl.op       = op;
    assign ctrl.status   = st;

endmodule

// ----- hdl/iiel_dpath.sv -----
`timescale 1ns / 1ps

module iiel_dpath
    import iiel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CMD_W-1:0]      in_cmd,
    input  logic [POS_W-1:0]      in_pos,
    input  logic [DATA_WIDTH-1:0] in_value,
    input  dp_ctrl_t              ctrl,
    output dp_stat_t              stat,
    output logic [DATA_WIDTH-1:0] read_value,
    output logic [ST_W-1:0]       status,
    output logic [CNT_W-1:0]      entry_count
);

    logic [CMD_W-1:0]      cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] entry_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] entry_next [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic [ST_W-1:0]       st_reg;
    logic [CNT_W-1:0]      cnt_out_reg;
    logic [IDX_W-1:0]      rd_idx;
    logic [CNT_W-1:0]      count_dec;

    assign count_dec = count_reg - CNT_W'(1);

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            cmd_reg <= in_cmd;
            pos_reg <= in_pos;
            val_reg <= in_value;
        end
    end

    // Status toward the controller
    assign stat.cmd        = cmd_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg >= CNT_W'(CAPACITY));
    assign stat.pos_gt_cnt = (pos_reg > count_reg);
    assign stat.pos_ge_cnt = (pos_reg >= count_reg);

    // Shift row: each cell picks its own value, its neighbor's or the new item
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_next[i] = entry_reg[i];
            case (ctrl.op)
                OP_APPEND:
                begin
                    if (count_reg == CNT_W'(i)) entry_next[i] = val_reg;
                end
                OP_INSERT:
                begin
                    if (pos_reg == POS_W'(i))
                        entry_next[i] = val_reg;
                    else if (i > 0 && pos_reg < POS_W'(i))
                        entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                end
                OP_ERASE:
                begin
                    if (i < CAPACITY - 1 && pos_reg <= POS_W'(i))
                        entry_next[i] = entry_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
                OP_WRITE:
                begin
                    if (pos_reg == POS_W'(i)) entry_next[i] = val_reg;
                end
                default:
                begin
                    entry_next[i] = entry_reg[i];
                end
            endcase
        end
    end

    // Pick the read slot and the new count
    always_comb
    begin
        rd_idx     = pos_reg[IDX_W-1:0];
        count_next = count_reg;
        case (ctrl.op) inside
            OP_FRONT:             rd_idx = '0;
            OP_BACK:              rd_idx = count_dec[IDX_W-1:0];
            OP_APPEND, OP_INSERT: count_next = count_reg + CNT_W'(1);
            OP_POP, OP_ERASE:     count_next = count_dec;
            OP_CLEAR:             count_next = '0;
            default:              rd_idx = pos_reg[IDX_W-1:0];
        endcase
        rd_next = '0;
        if (ctrl.op == OP_READ || ctrl.op == OP_FRONT || ctrl.op == OP_BACK)
            rd_next = entry_reg[rd_idx];
    end

    // Update the row on execute
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
                entry_reg[i] <= entry_next[i];
        end
    end

    // Hold the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.exec)
            count_reg <= count_next;
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            rd_reg      <= rd_next;
            st_reg      <= ctrl.status;
            cnt_out_reg <= count_next;
        end
    end

    assign read_value  = rd_reg;
    assign status      = st_reg;
    assign entry_count = cnt_out_reg;

endmodule
